### src/msap_pkg.sv
//------------------------------------------------------------------------------
// msap_pkg
// Shared types, register indexes, op codes and constants of the modulated
// allpass block.
//------------------------------------------------------------------------------
package msap_pkg;

   localparam int GAIN_W     = 18;
   localparam int DELAY_W    = 14;
   localparam int MDEPTH_W   = 11;
   localparam int PHASE_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int Q          = 16;   // fraction bits of the Q16 values
   localparam int QX_W       = 17;   // folded LFO phase, 0..65536
   localparam int POLY_W     = 18;   // polynomial accumulator
   localparam int LFO_W      = 18;   // signed LFO value, -65536..65536
   localparam int MB_W       = 19;   // narrow multiplier operand
   localparam int D_W        = 35;   // modulated delay in Q16, signed
   localparam int DIV_W      = 18;   // quotient bits of the coefficient divider
   localparam int DIV_STEPS  = 18;
   localparam int POLY_STEPS = 4;
   localparam int CNT_W      = 5;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd45875;
   localparam logic [POLY_W-1:0] POLY_SEED  = 18'd11;
   localparam logic [QX_W-1:0]   LFO_FULL   = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN       = 3'd0,
      REG_DELAY      = 3'd1,
      REG_MOD_EN     = 3'd2,
      REG_WAVE       = 3'd3,
      REG_MOD_DEPTH  = 3'd4,
      REG_PHASE_STEP = 3'd5
   } reg_idx_type;

   typedef enum logic [4:0] {
      OP_NONE      = 5'd0,
      OP_LOAD      = 5'd1,
      OP_RD_BASE   = 5'd2,
      OP_RD_TAKE   = 5'd3,
      OP_FOLD      = 5'd4,
      OP_TRI_TAKE  = 5'd5,
      OP_SQ_MUL    = 5'd6,
      OP_SQ_TAKE   = 5'd7,
      OP_POLY_MUL  = 5'd8,
      OP_POLY_TAKE = 5'd9,
      OP_SIN_MUL   = 5'd10,
      OP_SIN_TAKE  = 5'd11,
      OP_DEP_MUL   = 5'd12,
      OP_CLAMP     = 5'd13,
      OP_DIV_INIT  = 5'd14,
      OP_DIV_STEP  = 5'd15,
      OP_RD_RIGHT  = 5'd16,
      OP_RD_PREV   = 5'd17,
      OP_PREV_TAKE = 5'd18,
      OP_INT_MUL   = 5'd19,
      OP_INT_TAKE  = 5'd20,
      OP_G1_MUL    = 5'd21,
      OP_G1_TAKE   = 5'd22,
      OP_G2_MUL    = 5'd23,
      OP_G2_TAKE   = 5'd24
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] coef_sel;
   } cmd_type;

   typedef struct packed {
      logic mod_en;
      logic tri_wave;
      logic base_nz;
      logic out_free;
   } status_type;

   // sine polynomial coefficients, innermost first after the seed
   function automatic logic [POLY_W-1:0] poly_coef(input logic [1:0] sel);
      logic [POLY_W-1:0] c;
      case (sel)
         2'd0:    c = 18'd307;
         2'd1:    c = 18'd5223;
         2'd2:    c = 18'd42334;
         default: c = 18'd102944;
      endcase
      return c;
   endfunction

endpackage

### src/msap_ram.sv
//------------------------------------------------------------------------------
// msap_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module msap_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/msap_ctrl.sv
//------------------------------------------------------------------------------
// msap_ctrl
// Sequencer: walks a sample through the datapath, one op per unstalled cycle.
//------------------------------------------------------------------------------
module msap_ctrl
   import msap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [23:0] {
      S_IDLE      = 24'h000001,
      S_RD_BASE   = 24'h000002,
      S_RD_TAKE   = 24'h000004,
      S_FOLD      = 24'h000008,
      S_TRI_TAKE  = 24'h000010,
      S_SQ_MUL    = 24'h000020,
      S_SQ_TAKE   = 24'h000040,
      S_POLY_MUL  = 24'h000080,
      S_POLY_TAKE = 24'h000100,
      S_SIN_MUL   = 24'h000200,
      S_SIN_TAKE  = 24'h000400,
      S_DEP_MUL   = 24'h000800,
      S_CLAMP     = 24'h001000,
      S_DIV_INIT  = 24'h002000,
      S_DIV_STEP  = 24'h004000,
      S_RD_RIGHT  = 24'h008000,
      S_RD_PREV   = 24'h010000,
      S_PREV_TAKE = 24'h020000,
      S_INT_MUL   = 24'h040000,
      S_INT_TAKE  = 24'h080000,
      S_G1_MUL    = 24'h100000,
      S_G1_TAKE   = 24'h200000,
      S_G2_MUL    = 24'h400000,
      S_G2_TAKE   = 24'h800000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd.op       = OP_NONE;
      cmd.coef_sel = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (status.mod_en) begin
                  state_in = S_FOLD;
               end else if (status.base_nz) begin
                  state_in = S_RD_BASE;
               end else begin
                  state_in = S_G1_MUL;
               end
            end
         end
         S_RD_BASE: begin
            cmd.op   = OP_RD_BASE;
            state_in = S_RD_TAKE;
         end
         S_RD_TAKE: begin
            cmd.op   = OP_RD_TAKE;
            state_in = S_G1_MUL;
         end
         S_FOLD: begin
            cmd.op   = OP_FOLD;
            state_in = status.tri_wave ? S_TRI_TAKE : S_SQ_MUL;
         end
         S_TRI_TAKE: begin
            cmd.op   = OP_TRI_TAKE;
            state_in = S_DEP_MUL;
         end
         S_SQ_MUL: begin
            cmd.op   = OP_SQ_MUL;
            state_in = S_SQ_TAKE;
         end
         S_SQ_TAKE: begin
            cmd.op   = OP_SQ_TAKE;
            cnt_in   = '0;
            state_in = S_POLY_MUL;
         end
         S_POLY_MUL: begin
            cmd.op   = OP_POLY_MUL;
            state_in = S_POLY_TAKE;
         end
         S_POLY_TAKE: begin
            cmd.op = OP_POLY_TAKE;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(POLY_STEPS - 1)) begin
               state_in = S_SIN_MUL;
            end else begin
               state_in = S_POLY_MUL;
            end
         end
         S_SIN_MUL: begin
            cmd.op   = OP_SIN_MUL;
            state_in = S_SIN_TAKE;
         end
         S_SIN_TAKE: begin
            cmd.op   = OP_SIN_TAKE;
            state_in = S_DEP_MUL;
         end
         S_DEP_MUL: begin
            cmd.op   = OP_DEP_MUL;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = status.base_nz ? S_RD_RIGHT : S_INT_MUL;
            end
         end
         S_RD_RIGHT: begin
            cmd.op   = OP_RD_RIGHT;
            state_in = S_RD_PREV;
         end
         S_RD_PREV: begin
            cmd.op   = OP_RD_PREV;
            state_in = S_PREV_TAKE;
         end
         S_PREV_TAKE: begin
            cmd.op   = OP_PREV_TAKE;
            state_in = S_INT_MUL;
         end
         S_INT_MUL: begin
            cmd.op   = OP_INT_MUL;
            state_in = S_INT_TAKE;
         end
         S_INT_TAKE: begin
            cmd.op   = OP_INT_TAKE;
            state_in = S_G1_MUL;
         end
         S_G1_MUL: begin
            cmd.op   = OP_G1_MUL;
            state_in = S_G1_TAKE;
         end
         S_G1_TAKE: begin
            cmd.op   = OP_G1_TAKE;
            state_in = S_G2_MUL;
         end
         S_G2_MUL: begin
            cmd.op   = OP_G2_MUL;
            state_in = S_G2_TAKE;
         end
         S_G2_TAKE: begin
            // hold here while the previous result is still unclaimed
            if (status.out_free) begin
               cmd.op   = OP_G2_TAKE;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample accepted while another is in flight");

   a_mod_path: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.mod_en) |=> (state_ff == S_FOLD))
      else $error("modulated sample skipped the LFO");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP && cnt_ff == CNT_W'(DIV_STEPS - 1))
      |=> (state_ff != S_DIV_STEP))
      else $error("divider overran its step count");

endmodule

### src/msap_dp.sv
//------------------------------------------------------------------------------
// msap_dp
// Datapath: config registers, LFO, shared multiplier, coefficient divider,
// delay-line addressing, saturation and the output register.
//------------------------------------------------------------------------------
module msap_dp
   import msap_pkg::*;
#(
   parameter int DEPTH        = 16384,
   parameter int SINE_ENTRIES = 256,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  logic                           csr_valid,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]  rsp_sample_out,
   output logic                           ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]       ram_wr_addr,
   output logic [SAMPLE_BITS-1:0]         ram_wr_data,
   output logic                           ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]       ram_rd_addr,
   input  logic [SAMPLE_BITS-1:0]         ram_rd_data
);

   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = $clog2(DEPTH);
   localparam int MA  = SB + 2;
   localparam int PW  = MA + MB_W;
   localparam int SEB = $clog2(SINE_ENTRIES);
   localparam logic [PHASE_W-1:0] SINE_MASK =
      ~((PHASE_W'(1) << (PHASE_W - SEB)) - PHASE_W'(1));
   localparam logic signed [D_W-1:0] D_MAX = D_W'(DEPTH - 1) <<< Q;
   localparam logic signed [PW:0] SMAX = (PW+1)'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [PW:0] SMIN = -SMAX - (PW+1)'(1);

   function automatic logic signed [SB-1:0] sat(input logic signed [PW:0] v);
      logic signed [SB-1:0] r;
      if (v > SMAX) begin
         r = SB'(SMAX);
      end else if (v < SMIN) begin
         r = SB'(SMIN);
      end else begin
         r = SB'(v);
      end
      return r;
   endfunction

   // circular step back by n slots
   function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] a,
                                                input logic [AW-1:0] n);
      logic [AW:0] diff;
      diff = {1'b0, a} - {1'b0, n};
      if (diff[AW]) begin
         diff = diff + (AW+1)'(DEPTH);
      end
      return diff[AW-1:0];
   endfunction

   // config
   logic signed [GAIN_W-1:0] gain_ff, gain_in;
   logic [DELAY_W-1:0]       delay_ff, delay_in;
   logic                     mod_en_ff, mod_en_in;
   logic                     wave_ff, wave_in;
   logic [MDEPTH_W-1:0]      mdepth_ff, mdepth_in;
   logic [PHASE_W-1:0]       step_ff, step_in;

   // state with defined reset
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic [AW-1:0]            wa_ff, wa_in;
   logic                     wrapped_ff, wrapped_in;
   logic signed [SB-1:0]     li_ff, li_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [SB-1:0]     x_ff, x_in;
   logic signed [SB-1:0]     right_ff, right_in;
   logic signed [SB-1:0]     prev_ff, prev_in;
   logic signed [SB-1:0]     left_ff, left_in;
   logic signed [SB-1:0]     out_ff, out_in;
   logic [QX_W-1:0]          xq_ff, xq_in;
   logic                     neg_ff, neg_in;
   logic [QX_W-1:0]          x2_ff, x2_in;
   logic [POLY_W-1:0]        poly_ff, poly_in;
   logic signed [LFO_W-1:0]  lfo_ff, lfo_in;
   logic [AW-1:0]            n_ff, n_in;
   logic [Q-1:0]             f_ff, f_in;
   logic [QX_W-1:0]          den_ff, den_in;
   logic [QX_W-1:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]         qsh_ff, qsh_in;
   logic [AW-1:0]            ra_ff, ra_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic signed [PW-1:0]     prod_ff;

   logic signed [MA-1:0]     mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic                     mul_en;
   logic signed [PW-1:0]     prod_sh;
   logic [AW-1:0]            base;
   logic                     out_free;

   logic [PHASE_W-1:0]       ph;
   logic [30:0]              rr;
   logic [POLY_W-1:0]        sval;
   logic [QX_W-1:0]          vcap;
   logic signed [D_W-1:0]    dsum;
   logic signed [D_W-1:0]    dcl;
   logic [32:0]              num;
   logic [DIV_W-1:0]         rem2;
   logic signed [SB:0]       diff;
   logic signed [SB-1:0]     rd_val;

   assign prod_sh  = prod_ff >>> Q;
   assign base     = ({3'b0, delay_ff} > 17'(DEPTH - 1)) ? AW'(DEPTH - 1)
                                                         : AW'(delay_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_val   = rd_ok_ff ? $signed(ram_rd_data) : '0;

   assign status.mod_en   = mod_en_ff;
   assign status.tri_wave = wave_ff;
   assign status.base_nz  = (delay_ff != '0);
   assign status.out_free = out_free;

   // shared multiplier operand select
   always_comb begin
      mul_en = 1'b0;
      mul_a  = '0;
      mul_b  = '0;
      diff   = (SB+1)'(right_ff) - (SB+1)'(li_ff);
      case (cmd.op)
         OP_SQ_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(xq_ff);
            mul_b  = MB_W'(xq_ff);
         end
         OP_POLY_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(x2_ff);
            mul_b  = MB_W'(poly_ff);
         end
         OP_SIN_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(xq_ff);
            mul_b  = MB_W'(poly_ff);
         end
         OP_DEP_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(mdepth_ff);
            mul_b  = MB_W'(lfo_ff);
         end
         OP_INT_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(diff);
            mul_b  = MB_W'(qsh_ff);
         end
         OP_G1_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(right_ff);
            mul_b  = MB_W'(gain_ff);
         end
         OP_G2_MUL: begin
            mul_en = 1'b1;
            mul_a  = MA'(left_ff);
            mul_b  = MB_W'(0) - MB_W'(gain_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      gain_in      = gain_ff;
      delay_in     = delay_ff;
      mod_en_in    = mod_en_ff;
      wave_in      = wave_ff;
      mdepth_in    = mdepth_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      wa_in        = wa_ff;
      wrapped_in   = wrapped_ff;
      li_in        = li_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      right_in     = right_ff;
      prev_in      = prev_ff;
      left_in      = left_ff;
      out_in       = out_ff;
      xq_in        = xq_ff;
      neg_in       = neg_ff;
      x2_in        = x2_ff;
      poly_in      = poly_ff;
      lfo_in       = lfo_ff;
      n_in         = n_ff;
      f_in         = f_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      qsh_in       = qsh_ff;
      ra_in        = ra_ff;
      rd_ok_in     = rd_ok_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wa_ff;
      ram_wr_data  = left_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = back_addr(wa_ff, base);

      ph   = wave_ff ? phase_ff : (phase_ff & SINE_MASK);
      rr   = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
      sval = prod_ff[Q+POLY_W-1:Q];
      vcap = (sval > POLY_W'(LFO_FULL)) ? LFO_FULL : sval[QX_W-1:0];
      dsum = D_W'($signed({1'b0, delay_ff, {Q{1'b0}}})) + D_W'(prod_ff);
      if (dsum < 0) begin
         dcl = '0;
      end else if (dsum > D_MAX) begin
         dcl = D_MAX;
      end else begin
         dcl = dsum;
      end
      num  = {(LFO_FULL - QX_W'(f_ff)), {Q{1'b0}}};
      rem2 = {rem_ff, qsh_ff[DIV_W-1]};

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            REG_GAIN:       gain_in   = csr_data[GAIN_W-1:0];
            REG_DELAY:      delay_in  = csr_data[DELAY_W-1:0];
            REG_MOD_EN:     mod_en_in = csr_data[0];
            REG_WAVE:       wave_in   = csr_data[0];
            REG_MOD_DEPTH:  mdepth_in = csr_data[MDEPTH_W-1:0];
            REG_PHASE_STEP: step_in   = csr_data[PHASE_W-1:0];
            default: begin
            end
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            x_in     = req_sample_in;
            right_in = req_sample_in;
            prev_in  = '0;
            if (mod_en_ff) begin
               phase_in = phase_ff + step_ff;
            end
         end
         OP_RD_BASE: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = back_addr(wa_ff, base);
            rd_ok_in    = wrapped_ff || (ram_rd_addr < wa_ff);
         end
         OP_RD_TAKE: begin
            right_in = rd_val;
         end
         OP_FOLD: begin
            xq_in  = rr[30:14];
            neg_in = ph[31];
         end
         OP_TRI_TAKE: begin
            lfo_in = neg_ff ? -LFO_W'(xq_ff) : LFO_W'(xq_ff);
         end
         OP_SQ_TAKE: begin
            x2_in   = prod_ff[Q+QX_W-1:Q];
            poly_in = POLY_SEED;
         end
         OP_POLY_TAKE: begin
            poly_in = poly_coef(cmd.coef_sel) - prod_ff[Q+POLY_W-1:Q];
         end
         OP_SIN_TAKE: begin
            lfo_in = neg_ff ? -LFO_W'(vcap) : LFO_W'(vcap);
         end
         OP_CLAMP: begin
            n_in = dcl[Q+AW-1:Q];
            f_in = dcl[Q-1:0];
         end
         OP_DIV_INIT: begin
            den_in = LFO_FULL + QX_W'(f_ff);
            rem_in = QX_W'(num[32:DIV_W]);
            qsh_in = num[DIV_W-1:0];
         end
         OP_DIV_STEP: begin
            if (rem2 >= {1'b0, den_ff}) begin
               rem_in = QX_W'(rem2 - {1'b0, den_ff});
               qsh_in = {qsh_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem2[QX_W-1:0];
               qsh_in = {qsh_ff[DIV_W-2:0], 1'b0};
            end
         end
         OP_RD_RIGHT: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = back_addr(wa_ff, n_ff);
            ra_in       = ram_rd_addr;
            rd_ok_in    = wrapped_ff || (ram_rd_addr < wa_ff);
         end
         OP_RD_PREV: begin
            right_in    = rd_val;
            ram_rd_en   = 1'b1;
            ram_rd_addr = back_addr(ra_ff, AW'(1));
            rd_ok_in    = wrapped_ff || (ram_rd_addr < wa_ff);
         end
         OP_PREV_TAKE: begin
            prev_in = rd_val;
         end
         OP_INT_TAKE: begin
            right_in = sat((PW+1)'(prev_ff) + (PW+1)'(prod_sh));
            li_in    = right_in;
         end
         OP_G1_TAKE: begin
            left_in = sat((PW+1)'(x_ff) + (PW+1)'(prod_sh));
         end
         OP_G2_TAKE: begin
            out_in       = sat((PW+1)'(right_ff) + (PW+1)'(prod_sh));
            rsp_valid_in = 1'b1;
            ram_wr_en    = 1'b1;
            if (wa_ff == AW'(DEPTH - 1)) begin
               wa_in      = '0;
               wrapped_in = 1'b1;
            end else begin
               wa_in = wa_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         delay_ff     <= '0;
         mod_en_ff    <= 1'b0;
         wave_ff      <= 1'b0;
         mdepth_ff    <= '0;
         step_ff      <= '0;
         phase_ff     <= '0;
         wa_ff        <= '0;
         wrapped_ff   <= 1'b0;
         li_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         delay_ff     <= delay_in;
         mod_en_ff    <= mod_en_in;
         wave_ff      <= wave_in;
         mdepth_ff    <= mdepth_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         wa_ff        <= wa_in;
         wrapped_ff   <= wrapped_in;
         li_ff        <= li_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      right_ff <= right_in;
      prev_ff  <= prev_in;
      left_ff  <= left_in;
      out_ff   <= out_in;
      xq_ff    <= xq_in;
      neg_ff   <= neg_in;
      x2_ff    <= x2_in;
      poly_ff  <= poly_in;
      lfo_ff   <= lfo_in;
      n_ff     <= n_in;
      f_ff     <= f_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      qsh_ff   <= qsh_in;
      ra_ff    <= ra_in;
      rd_ok_ff <= rd_ok_in;
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_G2_TAKE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote an unclaimed beat");

   a_out_set: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_G2_TAKE) |=> (rsp_valid_ff && (wa_ff != $past(wa_ff))))
      else $error("finished sample did not post or advance the write slot");

endmodule

### src/modulated_schroeder_allpass.sv
//------------------------------------------------------------------------------
// modulated_schroeder_allpass
// Schroeder allpass on signed audio samples with an LFO-modulated,
// allpass-interpolated delay.
//------------------------------------------------------------------------------
// Usage:
//   req_*  : one sample per beat (req_valid / req_ready).
//   rsp_*  : one filtered sample per accepted input, in order.
//   csr_*  : register writes, index 0..5 = gain, delay_samples, mod_enable,
//            mod_waveform, mod_depth, phase_step; other indexes are dropped.
//            csr_ready is always high; write only while the block is idle.
// Steps per sample, from accept to rsp_valid:
//   unmodulated, zero delay ........ gain steps only
//   unmodulated, nonzero delay ..... delay-line read, gain steps
//   triangle LFO ................... fold, depth, clamp, divide, interpolate
//   sine LFO ....................... as triangle, plus a square and polynomial
//   All paths share one multiplier; the modulated ones add the 18-step divider.
// One sample is processed at a time; req_ready rises with rsp_valid, and the
// next sample can be accepted while rsp_valid is still high.
// The result sits in an output register: a stalled receiver only holds the
// next sample at its last step, never the acceptance of a new one.
// Reset (synchronous): registers to defaults, write slot, LFO phase and
// interpolator state to zero. The delay line is not swept; a fill mark
// makes never-written slots read as zero, so the block is ready at once.
//------------------------------------------------------------------------------
module modulated_schroeder_allpass
   import msap_pkg::*;
#(
   parameter int DEPTH        = 16384,
   parameter int SINE_ENTRIES = 256,
   parameter int SAMPLE_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int AW = $clog2(DEPTH);

   cmd_type                cmd;
   status_type             status;
   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [SAMPLE_BITS-1:0] ram_rd_data;

   // registers are plain flops, a write is taken every cycle
   assign csr_ready = 1'b1;

   msap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msap_dp #(
      .DEPTH        (DEPTH),
      .SINE_ENTRIES (SINE_ENTRIES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_en      (ram_rd_en),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   // delay line of past left-node values
   msap_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
